>>> rtl/bbbr_pkg.sv
`timescale 1ns / 1ps
// Types and constants shared by the byte-budget block ring.
package bbbr_pkg;

    localparam int unsigned MIB_SHIFT   = 20;
    localparam int unsigned SLOT_W      = 6;
    localparam int unsigned BUDGET_W    = 12;
    localparam int unsigned CFG_DATA_W  = 12;
    localparam int unsigned CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_SLOT_LIMIT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BUDGET_MIB = 1'b1;

    localparam logic [SLOT_W-1:0]   SLOT_LIMIT_RST = 6'd32;
    localparam logic [BUDGET_W-1:0] BUDGET_MIB_RST = 12'd16;

    localparam logic [1:0] MODE_PUSH = 2'd0;
    localparam logic [1:0] MODE_READ = 2'd1;
    localparam logic [1:0] MODE_INFO = 2'd2;

    localparam logic [1:0] KIND_EVICT = 2'd0;
    localparam logic [1:0] KIND_PUSH  = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;
    localparam logic [1:0] KIND_INFO  = 2'd3;

    localparam logic ST_OK        = 1'b0;
    localparam logic ST_NOT_FOUND = 1'b1;

    localparam logic signed [63:0] STAMP_MIN = 64'sh8000_0000_0000_0000;

    typedef struct packed {
        logic [SLOT_W-1:0]   slot_limit;
        logic [BUDGET_W-1:0] budget_mib;
    } t_cfg;

    typedef struct packed {
        logic [1:0]         mode;
        logic [5:0]         position;
        logic [23:0]        block_bytes;
        logic signed [63:0] first_stamp;
        logic signed [63:0] last_stamp;
        logic [31:0]        row_count;
    } t_item;

    typedef struct packed {
        logic [23:0]        bytes;
        logic signed [63:0] first;
        logic signed [63:0] last;
        logic [31:0]        rows;
    } t_entry;

    typedef struct packed {
        logic [1:0]  kind;
        logic        status;
        t_entry      entry;
        logic [5:0]  occupancy;
        logic [31:0] bytes_held;
        logic [63:0] rows_pushed;
        logic        final_res;
    } t_result;

endpackage

>>> rtl/bbbr_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module bbbr_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/bbbr_ctrl.sv
`timescale 1ns / 1ps
// Ring sequencer: descriptor memory, eviction loop, read and info replies.
module bbbr_ctrl #(
    parameter int unsigned RING_DEPTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_item_valid,
    input  bbbr_pkg::t_item  i_item,
    input  bbbr_pkg::t_cfg   i_cfg,
    input  logic             i_out_free,
    output logic             o_busy,
    output logic             o_res_load,
    output bbbr_pkg::t_result o_res
);
    import bbbr_pkg::*;

    localparam int unsigned AW   = $clog2(RING_DEPTH);
    localparam int unsigned CW   = $clog2(RING_DEPTH + 1);
    localparam int unsigned KW   = (CW > SLOT_W) ? CW : SLOT_W;
    localparam int unsigned SW   = KW + 1;
    localparam int unsigned EW   = $bits(t_entry);
    localparam int unsigned BUDW = BUDGET_W + MIB_SHIFT;

    localparam logic [SW-1:0] DEPTH_S = SW'(RING_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(RING_DEPTH);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_PUSH     = 3'd1;
    localparam logic [2:0] S_EVICT    = 3'd2;
    localparam logic [2:0] S_READ     = 3'd3;
    localparam logic [2:0] S_READ_OUT = 3'd4;
    localparam logic [2:0] S_INFO     = 3'd5;
    localparam logic [2:0] S_INFO_B   = 3'd6;
    localparam logic [2:0] S_INFO_OUT = 3'd7;

    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                              input logic [KW-1:0] k);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(k);
        if (sum >= DEPTH_S) begin
            sum = sum - DEPTH_S;
        end
        return sum[AW-1:0];
    endfunction

    logic [2:0]         r_state, n_state;
    t_item              r_item, n_item;
    logic [AW-1:0]      r_oldest, n_oldest;
    logic [CW-1:0]      r_held, n_held;
    logic [31:0]        r_bytes, n_bytes;
    logic [63:0]        r_rows, n_rows;
    logic signed [63:0] r_info_first, n_info_first;

    logic          ram_we;
    logic [AW-1:0] ram_wr_addr;
    t_entry        ram_wr_data;
    logic          ram_rd_en;
    logic [AW-1:0] ram_rd_addr;
    logic [EW-1:0] ram_rd_raw;
    t_entry        rd_entry;

    logic [SLOT_W-1:0] slot_eff;
    logic              evict_slots;
    logic [32:0]       byte_sum;
    logic [BUDW-1:0]   budget;
    logic              evict;
    logic              not_found;

    bbbr_ram #(
        .WIDTH (EW),
        .DEPTH (RING_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_raw)
    );

    assign rd_entry = t_entry'(ram_rd_raw);

    assign slot_eff    = (i_cfg.slot_limit == '0) ? SLOT_W'(1) : i_cfg.slot_limit;
    assign evict_slots = (KW'(r_held) >= KW'(slot_eff)) || (r_held >= DEPTH_C);
    assign budget      = {i_cfg.budget_mib, {MIB_SHIFT{1'b0}}};
    assign byte_sum    = {1'b0, r_bytes} + 33'(r_item.block_bytes);
    assign evict       = evict_slots || ((byte_sum > 33'(budget)) && (r_held != '0));
    assign not_found   = KW'(r_item.position) >= KW'(r_held);

    always_comb begin
        n_state      = r_state;
        n_item       = r_item;
        n_oldest     = r_oldest;
        n_held       = r_held;
        n_bytes      = r_bytes;
        n_rows       = r_rows;
        n_info_first = r_info_first;
        ram_we       = 1'b0;
        ram_wr_addr  = slot_of(r_oldest, KW'(r_held));
        ram_wr_data  = '{bytes: r_item.block_bytes, first: r_item.first_stamp,
                         last: r_item.last_stamp, rows: r_item.row_count};
        ram_rd_en    = 1'b0;
        ram_rd_addr  = r_oldest;
        o_res_load   = 1'b0;
        o_res        = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    n_item = i_item;
                    unique case (i_item.mode)
                        MODE_PUSH: n_state = S_PUSH;
                        MODE_READ: n_state = S_READ;
                        MODE_INFO: n_state = S_INFO;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_PUSH: begin
                if (evict) begin
                    ram_rd_en = 1'b1;
                    n_state   = S_EVICT;
                end else if (i_out_free) begin
                    ram_we     = 1'b1;
                    n_held     = r_held + CW'(1);
                    n_bytes    = r_bytes + 32'(r_item.block_bytes);
                    n_rows     = r_rows + 64'(r_item.row_count);
                    o_res_load = 1'b1;
                    o_res.kind        = KIND_PUSH;
                    o_res.status      = ST_OK;
                    o_res.entry       = ram_wr_data;
                    o_res.occupancy   = 6'(n_held);
                    o_res.bytes_held  = n_bytes;
                    o_res.rows_pushed = n_rows;
                    o_res.final_res   = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_EVICT: begin
                if (i_out_free) begin
                    n_bytes    = r_bytes - 32'(rd_entry.bytes);
                    n_oldest   = slot_of(r_oldest, KW'(1));
                    n_held     = r_held - CW'(1);
                    o_res_load = 1'b1;
                    o_res.kind        = KIND_EVICT;
                    o_res.status      = ST_OK;
                    o_res.entry       = rd_entry;
                    o_res.occupancy   = 6'(n_held);
                    o_res.bytes_held  = n_bytes;
                    o_res.rows_pushed = r_rows;
                    o_res.final_res   = 1'b0;
                    n_state           = S_PUSH;
                end
            end
            S_READ: begin
                if (not_found) begin
                    if (i_out_free) begin
                        o_res_load = 1'b1;
                        o_res.kind        = KIND_READ;
                        o_res.status      = ST_NOT_FOUND;
                        o_res.occupancy   = 6'(r_held);
                        o_res.bytes_held  = r_bytes;
                        o_res.rows_pushed = r_rows;
                        o_res.final_res   = 1'b1;
                        n_state           = S_IDLE;
                    end
                end else begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = slot_of(r_oldest, KW'(r_item.position));
                    n_state     = S_READ_OUT;
                end
            end
            S_READ_OUT: begin
                if (i_out_free) begin
                    o_res_load = 1'b1;
                    o_res.kind        = KIND_READ;
                    o_res.status      = ST_OK;
                    o_res.entry       = rd_entry;
                    o_res.occupancy   = 6'(r_held);
                    o_res.bytes_held  = r_bytes;
                    o_res.rows_pushed = r_rows;
                    o_res.final_res   = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_INFO: begin
                if (r_held == '0) begin
                    if (i_out_free) begin
                        o_res_load = 1'b1;
                        o_res.kind        = KIND_INFO;
                        o_res.status      = ST_OK;
                        o_res.entry.first = STAMP_MIN;
                        o_res.entry.last  = STAMP_MIN;
                        o_res.occupancy   = 6'(r_held);
                        o_res.bytes_held  = r_bytes;
                        o_res.rows_pushed = r_rows;
                        o_res.final_res   = 1'b1;
                        n_state           = S_IDLE;
                    end
                end else begin
                    ram_rd_en = 1'b1;
                    n_state   = S_INFO_B;
                end
            end
            S_INFO_B: begin
                n_info_first = rd_entry.first;
                ram_rd_en    = 1'b1;
                ram_rd_addr  = slot_of(r_oldest, KW'(r_held - CW'(1)));
                n_state      = S_INFO_OUT;
            end
            S_INFO_OUT: begin
                if (i_out_free) begin
                    o_res_load = 1'b1;
                    o_res.kind        = KIND_INFO;
                    o_res.status      = ST_OK;
                    o_res.entry.first = r_info_first;
                    o_res.entry.last  = rd_entry.last;
                    o_res.occupancy   = 6'(r_held);
                    o_res.bytes_held  = r_bytes;
                    o_res.rows_pushed = r_rows;
                    o_res.final_res   = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_oldest <= '0;
            r_held   <= '0;
            r_bytes  <= '0;
            r_rows   <= '0;
        end else begin
            r_state  <= n_state;
            r_oldest <= n_oldest;
            r_held   <= n_held;
            r_bytes  <= n_bytes;
            r_rows   <= n_rows;
        end
        r_item       <= n_item;
        r_info_first <= n_info_first;
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

>>> rtl/byte_budget_block_ring_unit.sv
`timescale 1ns / 1ps
// Top level of the byte-budget block ring: configuration, item ports and result register.
//
// Holds up to RING_DEPTH block descriptors in one memory with a single read port and
// registered read data; an item is taken only while the sequencer is idle. A push first
// evicts the oldest entries one by one while the slot limit or byte budget would be exceeded,
// a read fetches the entry at its position, and an info request reads the oldest and the
// newest entry. Results leave through one output register, so a new item can be taken
// while the last result still waits. The memory is not cleared after reset.
module byte_budget_block_ring_unit #(
    parameter int unsigned RING_DEPTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bbbr_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [bbbr_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_mode,
    input  logic [5:0]                          i_position,
    input  logic [23:0]                         i_block_bytes,
    input  logic signed [63:0]                  i_first_stamp,
    input  logic signed [63:0]                  i_last_stamp,
    input  logic [31:0]                         i_row_count,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [1:0]                          o_result_kind,
    output logic                                o_status,
    output logic [23:0]                         o_entry_bytes,
    output logic signed [63:0]                  o_entry_first,
    output logic signed [63:0]                  o_entry_last,
    output logic [31:0]                         o_entry_rows,
    output logic [5:0]                          o_occupancy,
    output logic [31:0]                         o_bytes_held,
    output logic [63:0]                         o_rows_pushed,
    output logic                                o_final_res
);
    import bbbr_pkg::*;

    logic [SLOT_W-1:0]   r_slot_limit;
    logic [BUDGET_W-1:0] r_budget_mib;
    logic                r_out_valid;
    t_result             r_res;

    t_cfg    cfg;
    t_item   item;
    t_result res;
    logic    busy;
    logic    res_load;
    logic    out_free;

    assign cfg  = '{slot_limit: r_slot_limit, budget_mib: r_budget_mib};
    assign item = '{mode: i_mode, position: i_position, block_bytes: i_block_bytes,
                    first_stamp: i_first_stamp, last_stamp: i_last_stamp,
                    row_count: i_row_count};

    assign out_free = !r_out_valid || !i_out_stall;

    bbbr_ctrl #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (i_in_valid),
        .i_item       (item),
        .i_cfg        (cfg),
        .i_out_free   (out_free),
        .o_busy       (busy),
        .o_res_load   (res_load),
        .o_res        (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_limit <= SLOT_LIMIT_RST;
            r_budget_mib <= BUDGET_MIB_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SLOT_LIMIT: r_slot_limit <= i_cfg_data[SLOT_W-1:0];
                CFG_BUDGET_MIB: r_budget_mib <= i_cfg_data[BUDGET_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (res_load) begin
            r_res <= res;
        end
    end

    assign o_in_stall    = busy;
    assign o_out_valid   = r_out_valid;
    assign o_result_kind = r_res.kind;
    assign o_status      = r_res.status;
    assign o_entry_bytes = r_res.entry.bytes;
    assign o_entry_first = r_res.entry.first;
    assign o_entry_last  = r_res.entry.last;
    assign o_entry_rows  = r_res.entry.rows;
    assign o_occupancy   = r_res.occupancy;
    assign o_bytes_held  = r_res.bytes_held;
    assign o_rows_pushed = r_res.rows_pushed;
    assign o_final_res   = r_res.final_res;

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_load |-> out_free)
        else $error("result loaded over a stalled result");

    a_evict_not_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_result_kind == KIND_EVICT)) |-> (!o_final_res && (o_status == ST_OK)))
        else $error("eviction result marked final or failed");

    a_reply_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_result_kind != KIND_EVICT)) |-> o_final_res)
        else $error("reply not marked final");

    a_idle_after_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_load && res.final_res) |=> !o_in_stall)
        else $error("sequencer busy after final result");

endmodule
